@@ rtl/core/ddpa_pkg.sv @@
// Shared types, constants and digit helpers for the decimal dot-product accumulator.
package ddpa_pkg;

    localparam int unsigned DIGIT_W  = 4;
    localparam int unsigned FIELD_W  = 40;
    localparam int unsigned IN_DIGITS = 10;
    localparam int unsigned GROUP_DIGITS = 10;
    localparam int unsigned GROUPS   = 4;
    // A column holds at most ten products of 81 plus a digit and an incoming carry.
    localparam int unsigned COL_W    = 11;
    localparam int unsigned CARRY_W  = 8;
    localparam int unsigned PROD_W   = 2 * DIGIT_W;
    // floor(v * 6554 / 65536) equals floor(v / 10) for every v below 2048.
    localparam int unsigned RECIP_W  = 13;
    localparam int unsigned RECIP_SH = 16;
    localparam logic [RECIP_W-1:0] RECIP_TEN = 13'd6554;
    localparam logic [COL_W-1:0]   TEN       = 11'd10;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

    typedef logic [DIGIT_W-1:0] t_digit;
    typedef logic [CARRY_W-1:0] t_carry;

    typedef struct packed {
        logic [FIELD_W-1:0] a_digits;
        logic [FIELD_W-1:0] b_digits;
        logic               last_pair;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_W-1:0] integer_upper;
        logic [FIELD_W-1:0] integer_lower;
        logic [FIELD_W-1:0] fraction_upper;
        logic [FIELD_W-1:0] fraction_lower;
        logic               overflowed;
    } t_out_item;

    // Control broadcast from the sequencer to every cell of the row.
    typedef struct packed {
        logic load;
        logic mul;
        logic clear;
    } t_cell_ctl;

    // Digit pos of a packed BCD word; nibbles above nine read as nine, and
    // positions past the input word read as zero.
    function automatic t_digit bcd_digit(input logic [FIELD_W-1:0] word,
                                         input int unsigned pos);
        t_digit v;
        v = '0;
        if (pos < IN_DIGITS) begin
            v = word[pos*DIGIT_W +: DIGIT_W];
            if (v > DIGIT_MAX) begin
                v = DIGIT_MAX;
            end
        end
        return v;
    endfunction

endpackage

@@ rtl/core/ddpa_if.sv @@
// Valid/ready channel interfaces for the input and result transactions.
interface ddpa_in_if;
    import ddpa_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ddpa_out_if;
    import ddpa_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/decimal_dot_product_accumulator.sv @@
// Top level of the decimal dot-product accumulator: sequencer, digit row and result register.
//
// Usage: each input transaction on i_in carries two fractions as packed BCD
// digits (a_digits, b_digits) and a last_pair flag. Nibbles above nine count
// as nine. All digit products are added into a row of SUM_DIGITS decimal
// cells, one cell per accumulator digit, and the carries are then resolved.
// When last_pair is set, one result transaction on o_out gives accumulator
// digits 39..0 as four packed BCD groups plus a sticky overflow flag, and
// the accumulator is cleared for the next dot product.
//
// Timing: the b digits move one cell up per cycle while each a digit is
// broadcast in turn in the product phase. The carry then ripples one cell
// per cycle along the row, and a last item then also loads the result
// register. One item is in work at a time; i_in.ready is high only while
// the block waits for the next item.
//
// Reset (synchronous, i_rst_n low) clears the accumulator, the overflow flag
// and the output valid. If the receiver stalls, the result stays in the
// output register; non-last items are still accepted, but a later last item
// waits at its result load, holding i_in.ready low, until the register is free.
module decimal_dot_product_accumulator import ddpa_pkg::*; #(
    parameter int unsigned FRACTION_DIGITS = 10,
    parameter int unsigned SUM_DIGITS      = 40
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ddpa_in_if.sink    i_in,
    ddpa_out_if.source o_out
);

    localparam int unsigned STEP_W = (FRACTION_DIGITS > 1) ? $clog2(FRACTION_DIGITS) : 1;
    localparam int unsigned A_W    = FRACTION_DIGITS * DIGIT_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MUL   = 4'b0010,
        S_CARRY = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic [A_W-1:0]    r_a, n_a;
    logic              r_last, n_last;
    logic              r_bnz, n_bnz;
    logic              r_lost, n_lost;
    logic              r_start, n_start;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    t_cell_ctl         w_ctl;
    t_digit            w_a_digit;
    logic              w_bnz_init;
    t_digit            w_b_load [SUM_DIGITS];
    t_digit            w_b      [SUM_DIGITS];
    logic              w_tok    [SUM_DIGITS];
    t_carry            w_carry  [SUM_DIGITS];
    t_digit            w_digit  [SUM_DIGITS];
    logic [FIELD_W-1:0] w_group [GROUPS];

    // The row of digit cells; b digits and carries move from cell k-1 to cell k.
    for (genvar k = 0; k < SUM_DIGITS; k++) begin : g_cell
        t_digit b_prev;
        logic   tok_in;
        t_carry carry_in;

        if (k == 0) begin : g_first
            assign b_prev   = '0;
            assign tok_in   = r_start;
            assign carry_in = '0;
        end else begin : g_rest
            assign b_prev   = w_b[k-1];
            assign tok_in   = w_tok[k-1];
            assign carry_in = w_carry[k-1];
        end

        if (k < FRACTION_DIGITS) begin : g_load
            assign w_b_load[k] = bcd_digit(i_in.data.b_digits, k);
        end else begin : g_zero
            assign w_b_load[k] = '0;
        end

        ddpa_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_a_digit (w_a_digit),
            .i_b_load  (w_b_load[k]),
            .i_b_prev  (b_prev),
            .i_tok     (tok_in),
            .i_carry   (carry_in),
            .o_b       (w_b[k]),
            .o_tok     (w_tok[k]),
            .o_carry   (w_carry[k]),
            .o_digit   (w_digit[k])
        );
    end

    // Output grouping; digits past the top of the row read as zero.
    for (genvar g = 0; g < GROUPS; g++) begin : g_group
        for (genvar n = 0; n < GROUP_DIGITS; n++) begin : g_digit
            if (g * GROUP_DIGITS + n < SUM_DIGITS) begin : g_have
                assign w_group[g][n*DIGIT_W +: DIGIT_W] = w_digit[g*GROUP_DIGITS + n];
            end else begin : g_none
                assign w_group[g][n*DIGIT_W +: DIGIT_W] = '0;
            end
        end
    end

    // When the row is shorter than the fraction, the high b digits start
    // beyond the top cell and count as already shifted out.
    always_comb begin
        w_bnz_init = 1'b0;
        for (int unsigned j = 0; j < FRACTION_DIGITS; j++) begin
            if (j >= SUM_DIGITS && bcd_digit(i_in.data.b_digits, j) != '0) begin
                w_bnz_init = 1'b1;
            end
        end
    end

    assign w_a_digit   = r_a[DIGIT_W-1:0];
    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_a         = r_a;
        n_last      = r_last;
        n_bnz       = r_bnz;
        n_lost      = r_lost;
        n_start     = 1'b0;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_ctl       = '0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    w_ctl.load = 1'b1;
                    for (int unsigned i = 0; i < FRACTION_DIGITS; i++) begin
                        n_a[i*DIGIT_W +: DIGIT_W] = bcd_digit(i_in.data.a_digits, i);
                    end
                    n_last  = i_in.data.last_pair;
                    n_bnz   = w_bnz_init;
                    n_step  = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                w_ctl.mul = 1'b1;
                // A nonzero product whose b digit has left the row lands in a
                // column above the accumulator.
                if (w_a_digit != '0 && r_bnz) begin
                    n_lost = 1'b1;
                end
                if (w_b[SUM_DIGITS-1] != '0) begin
                    n_bnz = 1'b1;
                end
                n_a  = r_a >> DIGIT_W;
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(FRACTION_DIGITS - 1)) begin
                    n_start = 1'b1;
                    n_state = S_CARRY;
                end
            end
            S_CARRY: begin
                if (w_tok[SUM_DIGITS-1]) begin
                    if (w_carry[SUM_DIGITS-1] != '0) begin
                        n_lost = 1'b1;
                    end
                    n_state = r_last ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out.integer_upper  = w_group[3];
                    n_out.integer_lower  = w_group[2];
                    n_out.fraction_upper = w_group[1];
                    n_out.fraction_lower = w_group[0];
                    n_out.overflowed     = r_lost;
                    n_out_valid          = 1'b1;
                    w_ctl.clear          = 1'b1;
                    n_lost               = 1'b0;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lost      <= 1'b0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lost      <= n_lost;
            r_start     <= n_start;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step <= n_step;
        r_a    <= n_a;
        r_last <= n_last;
        r_bnz  <= n_bnz;
        r_out  <= n_out;
    end

endmodule

@@ rtl/core/ddpa_cell.sv @@
// One accumulator digit: column multiply-accumulate, b-digit shift and carry step.
module ddpa_cell import ddpa_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_digit    i_a_digit,
    input  t_digit    i_b_load,
    input  t_digit    i_b_prev,
    input  logic      i_tok,
    input  t_carry    i_carry,
    output t_digit    o_b,
    output logic      o_tok,
    output t_carry    o_carry,
    output t_digit    o_digit
);

    logic [COL_W-1:0]         r_col;
    t_digit                   r_b;
    t_digit                   r_digit;
    logic                     r_tok;
    t_carry                   r_carry;
    logic [PROD_W-1:0]        w_prod;
    logic [COL_W-1:0]         w_sum;
    logic [COL_W+RECIP_W-1:0] w_recip;
    t_carry                   w_quot;
    logic [COL_W-1:0]         w_rem;

    assign w_prod  = PROD_W'(i_a_digit) * PROD_W'(r_b);
    assign w_sum   = r_col + COL_W'(r_digit) + COL_W'(i_carry);
    assign w_recip = (COL_W+RECIP_W)'(w_sum) * (COL_W+RECIP_W)'(RECIP_TEN);
    assign w_quot  = w_recip[RECIP_SH +: CARRY_W];
    assign w_rem   = w_sum - COL_W'(w_quot) * TEN;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit <= '0;
            r_tok   <= 1'b0;
        end else begin
            r_tok <= i_tok;
            if (i_ctl.clear) begin
                r_digit <= '0;
            end else if (i_tok) begin
                r_digit <= w_rem[DIGIT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_b   <= i_b_load;
            r_col <= '0;
        end else if (i_ctl.mul) begin
            r_b   <= i_b_prev;
            r_col <= r_col + COL_W'(w_prod);
        end
        if (i_tok) begin
            r_carry <= w_quot;
        end
    end

    assign o_b     = r_b;
    assign o_tok   = r_tok;
    assign o_carry = r_carry;
    assign o_digit = r_digit;

endmodule
